### rtl/voxhash_pkg.sv
// Shared types and constants of the voxel occupancy hash table.
package voxhash_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_FACES  = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [31:0] PRIME_X = 32'd73856093;
   localparam logic [31:0] PRIME_Y = 32'd19349663;
   localparam logic [31:0] PRIME_Z = 32'd83492791;

   localparam logic [3:0] HASH_BITS_RESET = 4'd12;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_HASH  = 6'b000100,
      ST_HEAD  = 6'b001000,
      ST_HEADQ = 6'b010000,
      ST_WALK  = 6'b100000
   } state_type;

endpackage

### rtl/voxhash_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module voxhash_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/voxhash_hash.sv
// Bucket hash: registered coordinate-times-prime products, then XOR and mask.
module voxhash_hash #(
   parameter int HW = 12,
   parameter int C  = 16
) (
   input  logic                clock,
   input  logic signed [C:0]   probe_x,
   input  logic signed [C:0]   probe_y,
   input  logic signed [C:0]   probe_z,
   input  logic [3:0]          hash_bits,
   output logic [HW-1:0]       bucket
);

   // Only the low HW bits of each product reach the bucket, and they depend
   // only on the low HW bits of both operands.
   logic signed [31:0] ext_x, ext_y, ext_z;
   logic [2*HW-1:0]    prod_x, prod_y, prod_z;
   logic [HW-1:0]      hx_ff, hy_ff, hz_ff;
   logic [HW-1:0]      mask;

   always_comb begin
      ext_x  = 32'(probe_x);
      ext_y  = 32'(probe_y);
      ext_z  = 32'(probe_z);
      prod_x = ext_x[HW-1:0] * voxhash_pkg::PRIME_X[HW-1:0];
      prod_y = ext_y[HW-1:0] * voxhash_pkg::PRIME_Y[HW-1:0];
      prod_z = ext_z[HW-1:0] * voxhash_pkg::PRIME_Z[HW-1:0];
   end

   always_ff @(posedge clock) begin
      hx_ff <= prod_x[HW-1:0];
      hy_ff <= prod_y[HW-1:0];
      hz_ff <= prod_z[HW-1:0];
   end

   always_comb begin
      for (int i = 0; i < HW; i++) begin
         mask[i] = (i < int'(hash_bits));
      end
   end

   assign bucket = (hx_ff ^ hy_ff ^ hz_ff) & mask;

endmodule

### rtl/voxel_occupancy_hash_table.sv
// Voxel occupancy hash table: chained spatial hash with head and pool memories.
// An insert or lookup passes the states ST_HASH, ST_HEAD and ST_HEADQ, then walks the chain
// with one pool read per entry visited; a face query makes seven such probes.
// Throughput: one item at a time; the next item is accepted once the result is loaded.
// Reset: synchronous; a clearing pass over all 2**BUCKET_BITS bucket heads empties them
// while no item is accepted. hash_bits resets to 12, the cell count to zero.
module voxel_occupancy_hash_table #(
   parameter int BUCKET_BITS = 12,
   parameter int POOL_DEPTH  = 4096,
   parameter int COORD_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   // Input item, from bit 0: opcode(2), cell_x, cell_y, cell_z, owner_tag(16), zero pad.
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [((18 + 3*COORD_BITS + 7) / 8)*8-1:0] req_tdata,
   // Result item, from bit 0: status(2), found(1), owner_out(16), face_mask(6),
   // cell_total, zero pad.
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((25 + $clog2(POOL_DEPTH+1) + 7) / 8)*8-1:0] rsp_tdata,
   // Configuration: hash_bits.
   input  logic                                        csr_wen,
   input  logic [3:0]                                  csr_wdata
);

   localparam int C     = COORD_BITS;
   localparam int HW    = BUCKET_BITS;
   localparam int PW    = $clog2(POOL_DEPTH);
   localparam int CW    = $clog2(POOL_DEPTH + 1);
   localparam int IN_TW = ((18 + 3*C + 7) / 8) * 8;
   localparam int OUT_W = 25 + CW;
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
   localparam int HEAD_W = 1 + PW;
   localparam int POOL_W = 1 + PW + 16 + 3*C;
   // Pool entry layout, from bit 0: x, y, z, owner, link, link valid.
   localparam int P_OWN = 3*C;
   localparam int P_LNK = 3*C + 16;
   localparam int P_LV  = 3*C + 16 + PW;

   voxhash_pkg::state_type state_ff, state_in;

   logic [1:0]          op_ff, op_in;
   logic signed [C-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [15:0]         tag_ff, tag_in;
   logic [2:0]          probe_ff, probe_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [3:0]          hb_ff;
   logic                found_ff, found_in;
   logic [15:0]         owner_ff, owner_in;
   logic [1:0]          status_ff, status_in;
   logic [5:0]          mask_ff, mask_in;
   logic [HW-1:0]       bucket_ff, bucket_in;
   logic                headv_ff, headv_in;
   logic [PW-1:0]       headp_ff, headp_in;
   logic [HW-1:0]       sweep_ff, sweep_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic                done_ff, done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_TW-1:0]   rsp_data_ff, rsp_data_in;

   // Probe coordinates: the cell itself for probe 0, then the six neighbors.
   logic signed [C:0] px, py, pz;
   logic [HW-1:0]     bucket;

   logic              head_we, head_re, pool_we, pool_re;
   logic [HW-1:0]     head_waddr;
   logic [HEAD_W-1:0] head_wdata, head_rdata;
   logic [PW-1:0]     pool_waddr, pool_raddr;
   logic [POOL_W-1:0] pool_wdata, pool_rdata;

   logic              probe_end, probe_hit, rsp_free;
   logic signed [C:0] sx, sy, sz;

   always_comb begin
      px = {x_ff[C-1], x_ff} + (C+1)'(probe_ff == 3'd1) - (C+1)'(probe_ff == 3'd2);
      py = {y_ff[C-1], y_ff} + (C+1)'(probe_ff == 3'd3) - (C+1)'(probe_ff == 3'd4);
      pz = {z_ff[C-1], z_ff} + (C+1)'(probe_ff == 3'd5) - (C+1)'(probe_ff == 3'd6);
   end

   voxhash_hash #(.HW(HW), .C(C)) u_hash (
      .clock     (clock),
      .probe_x   (px),
      .probe_y   (py),
      .probe_z   (pz),
      .hash_bits (hb_ff),
      .bucket    (bucket)
   );

   voxhash_ram #(.WIDTH(HEAD_W), .DEPTH(2**HW)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (head_re),
      .rd_addr (bucket),
      .rd_data (head_rdata)
   );

   voxhash_ram #(.WIDTH(POOL_W), .DEPTH(POOL_DEPTH)) u_pool_ram (
      .clock   (clock),
      .wr_en   (pool_we),
      .wr_addr (pool_waddr),
      .wr_data (pool_wdata),
      .rd_en   (pool_re),
      .rd_addr (pool_raddr),
      .rd_data (pool_rdata)
   );

   assign req_tready = (state_ff == voxhash_pkg::ST_IDLE) && !done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Stored coordinates widened by one bit, so an out-of-range neighbor never matches.
   always_comb begin
      sx = {pool_rdata[C-1], pool_rdata[C-1:0]};
      sy = {pool_rdata[2*C-1], pool_rdata[2*C-1:C]};
      sz = {pool_rdata[3*C-1], pool_rdata[3*C-1:2*C]};
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      tag_in      = tag_ff;
      probe_in    = probe_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      owner_in    = owner_ff;
      status_in   = status_ff;
      mask_in     = mask_ff;
      bucket_in   = bucket_ff;
      headv_in    = headv_ff;
      headp_in    = headp_ff;
      sweep_in    = sweep_ff;
      clr_rsp_in  = clr_rsp_ff;
      done_in     = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      head_we     = 1'b0;
      head_waddr  = sweep_ff;
      head_wdata  = '0;
      head_re     = 1'b0;
      pool_we     = 1'b0;
      pool_waddr  = count_ff[PW-1:0];
      pool_wdata  = {headv_ff, headp_ff, tag_ff, z_ff, y_ff, x_ff};
      pool_re     = 1'b0;
      pool_raddr  = headp_ff;
      probe_end   = 1'b0;
      probe_hit   = 1'b0;

      // A finished item waits here until the output register is free.
      if (done_ff && rsp_free) begin
         done_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = OUT_TW'({count_ff, mask_ff, owner_ff, found_ff, status_ff});
      end

      case (state_ff)
         voxhash_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in     = req_tdata[1:0];
               x_in      = req_tdata[2 +: C];
               y_in      = req_tdata[2 + C +: C];
               z_in      = req_tdata[2 + 2*C +: C];
               tag_in    = req_tdata[2 + 3*C +: 16];
               probe_in  = '0;
               found_in  = 1'b0;
               owner_in  = '0;
               status_in = voxhash_pkg::STATUS_OK;
               mask_in   = '0;
               if (req_tdata[1:0] == voxhash_pkg::OP_CLEAR) begin
                  sweep_in   = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = voxhash_pkg::ST_CLEAR;
               end else begin
                  state_in = voxhash_pkg::ST_HASH;
               end
            end
         end
         voxhash_pkg::ST_CLEAR: begin
            head_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               count_in = '0;
               done_in  = clr_rsp_ff;
               state_in = voxhash_pkg::ST_IDLE;
            end
         end
         voxhash_pkg::ST_HASH: begin
            state_in = voxhash_pkg::ST_HEAD;
         end
         voxhash_pkg::ST_HEAD: begin
            head_re   = 1'b1;
            bucket_in = bucket;
            state_in  = voxhash_pkg::ST_HEADQ;
         end
         voxhash_pkg::ST_HEADQ: begin
            headv_in = head_rdata[PW];
            headp_in = head_rdata[PW-1:0];
            if (head_rdata[PW] && (CW'(head_rdata[PW-1:0]) < count_ff)) begin
               pool_re    = 1'b1;
               pool_raddr = head_rdata[PW-1:0];
               state_in   = voxhash_pkg::ST_WALK;
            end else begin
               probe_end = 1'b1;
            end
         end
         voxhash_pkg::ST_WALK: begin
            if (sx == px && sy == py && sz == pz) begin
               probe_end = 1'b1;
               probe_hit = 1'b1;
            end else if (pool_rdata[P_LV] &&
                         (CW'(pool_rdata[P_LNK +: PW]) < count_ff)) begin
               pool_re    = 1'b1;
               pool_raddr = pool_rdata[P_LNK +: PW];
            end else begin
               probe_end = 1'b1;
            end
         end
         default: begin
            state_in = voxhash_pkg::ST_IDLE;
         end
      endcase

      // Outcome of one probe: the cell itself first, then neighbors on a face query.
      if (probe_end) begin
         if (probe_ff == 3'd0) begin
            found_in = probe_hit;
            owner_in = probe_hit ? pool_rdata[P_OWN +: 16] : 16'd0;
            if (op_ff == voxhash_pkg::OP_INSERT) begin
               if (probe_hit) begin
                  status_in = voxhash_pkg::STATUS_PRESENT;
               end else if (count_ff == CW'(POOL_DEPTH)) begin
                  status_in = voxhash_pkg::STATUS_FULL;
               end else begin
                  // Push the new cell onto the front of its bucket's chain.
                  pool_we    = 1'b1;
                  if (state_ff == voxhash_pkg::ST_HEADQ) begin
                     pool_wdata = {head_rdata, tag_ff, z_ff, y_ff, x_ff};
                  end
                  head_we    = 1'b1;
                  head_waddr = bucket_ff;
                  head_wdata = {1'b1, count_ff[PW-1:0]};
                  count_in   = count_ff + 1'b1;
                  found_in   = 1'b1;
                  owner_in   = tag_ff;
               end
            end
            if (op_ff == voxhash_pkg::OP_FACES) begin
               probe_in = 3'd1;
               state_in = voxhash_pkg::ST_HASH;
            end else begin
               done_in  = 1'b1;
               state_in = voxhash_pkg::ST_IDLE;
            end
         end else begin
            mask_in = mask_ff | (6'(!probe_hit) << (probe_ff - 3'd1));
            if (probe_ff == 3'd6) begin
               done_in  = 1'b1;
               state_in = voxhash_pkg::ST_IDLE;
            end else begin
               probe_in = probe_ff + 3'd1;
               state_in = voxhash_pkg::ST_HASH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= voxhash_pkg::ST_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         hb_ff        <= voxhash_pkg::HASH_BITS_RESET;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            hb_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      tag_ff      <= tag_in;
      probe_ff    <= probe_in;
      found_ff    <= found_in;
      owner_ff    <= owner_in;
      status_ff   <= status_in;
      mask_ff     <= mask_in;
      bucket_ff   <= bucket_in;
      headv_ff    <= headv_in;
      headp_ff    <= headp_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### tb/voxel_hash_checker.sv
// Checker: predicts every result of the voxel hash table and compares it with the block.
`timescale 1ns / 1ps
module voxel_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [3:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int NUM_BUCKETS = 4096;
   localparam int POOL_SIZE   = 4096;

   typedef struct packed {
      logic [12:0] total;
      logic [5:0]  faces;
      logic [15:0] owner;
      logic        found;
      logic [1:0]  status;
   } voxel_result_type;

   logic [3:0]  hash_bits_q;
   int          head_index [NUM_BUCKETS];
   bit          head_used  [NUM_BUCKETS];
   int          pool_x [POOL_SIZE];
   int          pool_y [POOL_SIZE];
   int          pool_z [POOL_SIZE];
   logic [15:0] pool_owner [POOL_SIZE];
   int          pool_next  [POOL_SIZE];
   bit          next_used  [POOL_SIZE];
   int          cells_stored;
   voxel_result_type expected_results [$];

   assign pending_count = expected_results.size();

   function automatic int bucket_index(int x, int y, int z);
      bit [31:0] ux, uy, uz, h, mask;
      int        nbits;
      ux = x;
      uy = y;
      uz = z;
      h = (ux * voxhash_pkg::PRIME_X) ^ (uy * voxhash_pkg::PRIME_Y) ^
          (uz * voxhash_pkg::PRIME_Z);
      nbits = (hash_bits_q > 12) ? 12 : hash_bits_q;
      mask = (32'd1 << nbits) - 32'd1;
      return int'(h & mask);
   endfunction

   function automatic bit locate_cell(int x, int y, int z, output int where);
      int b, i, steps;
      bit live;
      b = bucket_index(x, y, z);
      live = head_used[b];
      i = head_index[b];
      steps = 0;
      where = 0;
      while (live && i < cells_stored && steps <= cells_stored) begin
         if (pool_x[i] == x && pool_y[i] == y && pool_z[i] == z) begin
            where = i;
            return 1;
         end
         live = next_used[i];
         i = pool_next[i];
         steps++;
      end
      return 0;
   endfunction

   function automatic voxel_result_type predict_result(logic [71:0] item);
      voxel_result_type r;
      logic [1:0] op;
      int x, y, z, idx, b, dummy;
      op = item[1:0];
      x = int'($signed(item[17:2]));
      y = int'($signed(item[33:18]));
      z = int'($signed(item[49:34]));
      r = '0;
      if (op == voxhash_pkg::OP_CLEAR) begin
         foreach (head_used[k]) head_used[k] = 0;
         cells_stored = 0;
      end else if (op == voxhash_pkg::OP_INSERT) begin
         if (locate_cell(x, y, z, idx)) begin
            r.status = voxhash_pkg::STATUS_PRESENT;
            r.found = 1;
            r.owner = pool_owner[idx];
         end else if (cells_stored >= POOL_SIZE) begin
            r.status = voxhash_pkg::STATUS_FULL;
         end else begin
            b = bucket_index(x, y, z);
            pool_x[cells_stored] = x;
            pool_y[cells_stored] = y;
            pool_z[cells_stored] = z;
            pool_owner[cells_stored] = item[65:50];
            pool_next[cells_stored] = head_index[b];
            next_used[cells_stored] = head_used[b];
            head_index[b] = cells_stored;
            head_used[b] = 1;
            cells_stored++;
            r.found = 1;
            r.owner = item[65:50];
         end
      end else begin
         if (locate_cell(x, y, z, idx)) begin
            r.found = 1;
            r.owner = pool_owner[idx];
         end
         if (op == voxhash_pkg::OP_FACES) begin
            // Neighbors are formed in 32-bit arithmetic, so a step past the edge never hits.
            r.faces[0] = !locate_cell(x + 1, y, z, dummy);
            r.faces[1] = !locate_cell(x - 1, y, z, dummy);
            r.faces[2] = !locate_cell(x, y + 1, z, dummy);
            r.faces[3] = !locate_cell(x, y - 1, z, dummy);
            r.faces[4] = !locate_cell(x, y, z + 1, dummy);
            r.faces[5] = !locate_cell(x, y, z - 1, dummy);
         end
      end
      r.total = 13'(cells_stored);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      voxel_result_type got, want;
      if (reset) begin
         hash_bits_q <= voxhash_pkg::HASH_BITS_RESET;
         foreach (head_used[k]) head_used[k] = 0;
         cells_stored = 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_result(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[37:0];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result item, status", got.status, -1);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status) report_mismatch("status", got.status, want.status);
               if (got.found !== want.found) report_mismatch("found", got.found, want.found);
               if (got.owner !== want.owner) report_mismatch("owner_out", got.owner, want.owner);
               if (got.faces !== want.faces)
                  report_mismatch("face_mask", got.faces, want.faces);
               if (got.total !== want.total)
                  report_mismatch("cell_total", got.total, want.total);
            end
         end
         if (csr_wen) hash_bits_q <= csr_wdata;
      end
   end

endmodule

### tb/tb_voxel_occupancy_hash_table.sv
// Testbench top: stimulus, receiver stalls and verdict for the voxel occupancy hash table.
`timescale 1ns / 1ps
module tb_voxel_occupancy_hash_table;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [3:0]  csr_wdata = '0;
   int          fail_count;
   int          pending_count;

   // Sender burst bookkeeping and totals for the summary.
   int burst_left = 0;
   int items_sent = 0;
   int phase_count = 0;

   // Coordinate bases for the random part; the small cube around a base gives hits.
   int base_x, base_y, base_z;

   always #5 clock = ~clock;

   voxel_occupancy_hash_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   voxel_hash_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // The receiver switches between always-ready stretches and stretches of random stalls,
   // so stalls land on every phase of the block's work.
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(5, 60);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 4) == 0);
         end
      endcase
   end

   // Sends one item. The valid stays high across a burst; between bursts it may drop for a
   // random gap. Acceptance is judged on the falling edge, where ready is stable.
   task automatic send_item(logic [1:0] op, int x, int y, int z, logic [15:0] tag);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, tag, z[15:0], y[15:0], x[15:0], op};
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Drops the valid and waits until every expected result has come.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_hash_bits(logic [3:0] value);
      drain_results();
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      phase_count++;
   endtask

   // Picks one coordinate: mostly near the phase base, sometimes at the edges or anywhere.
   function automatic int pick_coord(int base);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return base + $urandom_range(0, 3);
      if (sel < 80) return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 1)
                                                  : -32768 + $urandom_range(0, 1);
      return int'($signed(16'($urandom())));
   endfunction

   task automatic random_items(int count);
      int sel;
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 2) op = voxhash_pkg::OP_CLEAR;
         else if (sel < 42) op = voxhash_pkg::OP_INSERT;
         else if (sel < 70) op = voxhash_pkg::OP_LOOKUP;
         else op = voxhash_pkg::OP_FACES;
         send_item(op, pick_coord(base_x), pick_coord(base_y), pick_coord(base_z),
                   16'($urandom()));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every operation, duplicates, absent cells and the coordinate edges.
      write_hash_bits(4'd12);
      send_item(voxhash_pkg::OP_CLEAR, 0, 0, 0, 16'h0000);
      send_item(voxhash_pkg::OP_INSERT, 0, 0, 0, 16'hFFFF);
      send_item(voxhash_pkg::OP_INSERT, 0, 0, 0, 16'h1234);
      send_item(voxhash_pkg::OP_LOOKUP, 0, 0, 0, 16'h0000);
      send_item(voxhash_pkg::OP_LOOKUP, 5, -5, 7, 16'h0000);
      send_item(voxhash_pkg::OP_INSERT, 1, 0, 0, 16'h0001);
      send_item(voxhash_pkg::OP_INSERT, 0, -1, 0, 16'h0002);
      send_item(voxhash_pkg::OP_INSERT, 0, 0, 1, 16'h0003);
      send_item(voxhash_pkg::OP_FACES, 0, 0, 0, 16'h0000);
      send_item(voxhash_pkg::OP_FACES, 0, 1, 0, 16'h0000);
      send_item(voxhash_pkg::OP_INSERT, 32767, -32768, 32767, 16'h0000);
      send_item(voxhash_pkg::OP_FACES, 32767, -32768, 32767, 16'h0000);
      send_item(voxhash_pkg::OP_INSERT, -32768, 32767, -32768, 16'hA5A5);
      send_item(voxhash_pkg::OP_FACES, -32768, 32767, -32768, 16'h0000);
      send_item(voxhash_pkg::OP_LOOKUP, -32768, 32767, -32768, 16'h0000);
      send_item(voxhash_pkg::OP_FACES, 32766, -32767, 32766, 16'h0000);
      send_item(voxhash_pkg::OP_CLEAR, 0, 0, 0, 16'h0000);
      send_item(voxhash_pkg::OP_LOOKUP, 0, 0, 0, 16'h0000);
      send_item(voxhash_pkg::OP_FACES, 0, 0, 0, 16'h0000);

      // Fill the pool to capacity, then drop inserts and repeat a duplicate.
      for (int i = 0; i < 4096; i++)
         send_item(voxhash_pkg::OP_INSERT, i, -i, i ^ 5, 16'(i * 7));
      send_item(voxhash_pkg::OP_INSERT, 9000, 9000, 9000, 16'h0BAD);
      send_item(voxhash_pkg::OP_INSERT, -9000, 1, 2, 16'h0BAD);
      send_item(voxhash_pkg::OP_INSERT, 17, -17, 17 ^ 5, 16'hBEEF);
      send_item(voxhash_pkg::OP_LOOKUP, 4095, -4095, 4095 ^ 5, 16'h0000);
      send_item(voxhash_pkg::OP_FACES, 100, -100, 100 ^ 5, 16'h0000);
      send_item(voxhash_pkg::OP_CLEAR, 0, 0, 0, 16'h0000);

      // Random part over several bucket widths; cells carry over some changes of the width.
      base_x = 0; base_y = 0; base_z = 0;
      random_items(250);
      write_hash_bits(4'd0);
      base_x = 32764; base_y = -32768; base_z = 100;
      random_items(300);
      write_hash_bits(4'd1);
      base_x = -32768; base_y = 32764; base_z = -32768;
      random_items(300);
      write_hash_bits(4'd15);
      base_x = -50; base_y = 1234; base_z = 32764;
      random_items(300);
      write_hash_bits(4'd5);
      base_x = 7; base_y = -7; base_z = 0;
      random_items(300);
      write_hash_bits(4'd12);
      random_items(100);

      drain_results();
      $display("Sent %0d items with %0d writes of the hash width (0, 1, 5, 12 and 15),",
               items_sent, phase_count);
      $display("with a pool filled to capacity, edge coordinates and receiver stalls.");
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #50ms;
      $display("Timeout with %0d results outstanding", pending_count);
      $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
rtl/voxhash_pkg.sv
rtl/voxhash_ram.sv
rtl/voxhash_hash.sv
rtl/voxel_occupancy_hash_table.sv
tb/voxel_hash_checker.sv
tb/tb_voxel_occupancy_hash_table.sv
